[rtl/macd_pkg.sv]
package macd_pkg;

    localparam int PRICE_WIDTH      = 32;
    localparam int WEIGHT_FRAC_BITS = 24;

    // configuration
    localparam int CFG_W     = 10;
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_FAST   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SLOW   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SIGNAL = 2'd2;

    localparam logic [CFG_W-1:0] FAST_PERIOD_RST   = 10'd12;
    localparam logic [CFG_W-1:0] SLOW_PERIOD_RST   = 10'd26;
    localparam logic [CFG_W-1:0] SIGNAL_PERIOD_RST = 10'd9;

    // weight 2/(p+1) in Q1.FRAC
    localparam int W_W     = WEIGHT_FRAC_BITS + 1;
    localparam int DEN_W   = CFG_W + 1;
    localparam int DVD_W   = WEIGHT_FRAC_BITS + 2;
    localparam int DCNT_W  = $clog2(DVD_W);
    localparam logic [63:0] W_NUM = 64'd1 << (WEIGHT_FRAC_BITS + 1);

    typedef logic [W_W-1:0] t_weight;

    localparam t_weight WEIGHT_ONE = t_weight'(64'd1 << WEIGHT_FRAC_BITS);
    localparam t_weight FAST_W_RST = t_weight'(
        (W_NUM + (64'(FAST_PERIOD_RST) + 64'd1) / 2) / (64'(FAST_PERIOD_RST) + 64'd1));
    localparam t_weight SLOW_W_RST = t_weight'(
        (W_NUM + (64'(SLOW_PERIOD_RST) + 64'd1) / 2) / (64'(SLOW_PERIOD_RST) + 64'd1));
    localparam t_weight SIGNAL_W_RST = t_weight'(
        (W_NUM + (64'(SIGNAL_PERIOD_RST) + 64'd1) / 2) / (64'(SIGNAL_PERIOD_RST) + 64'd1));

    typedef struct packed {
        t_weight fast;
        t_weight slow;
        t_weight signal;
    } t_weights;

    // datapath widths
    localparam int AVG_W  = PRICE_WIDTH + WEIGHT_FRAC_BITS;   // price averages, unsigned
    localparam int SIG_W  = AVG_W + 1;                        // DIF and signal average, signed
    localparam int DIFF_W = AVG_W + 2;                        // EMA error term, signed
    localparam int LO_W   = (DIFF_W + 1) / 2;
    localparam int HI_W   = DIFF_W - LO_W;
    localparam int MA_W   = LO_W + 1;
    localparam int MB_W   = W_W + 1;
    localparam int PROD_W = MA_W + MB_W;
    localparam int ACC_W  = DIFF_W + W_W;

    // result widths
    localparam int DIF_W      = PRICE_WIDTH + 1;
    localparam int HIST_W     = PRICE_WIDTH + 2;
    localparam int HIST_CMP_W = DIFF_W - WEIGHT_FRAC_BITS + 1;
    localparam logic signed [HIST_CMP_W-1:0] HIST_MAX =
        HIST_CMP_W'((64'd1 << (PRICE_WIDTH + 1)) - 64'd2);
    localparam logic signed [HIST_CMP_W-1:0] HIST_MIN = -HIST_MAX;

endpackage

[rtl/macd_if.sv]
interface macd_in_if;
    logic                              valid;
    logic                              ready;
    logic [macd_pkg::PRICE_WIDTH-1:0]  close_price;
    logic                              series_start;

    modport source (output valid, output close_price, output series_start, input ready);
    modport sink   (input valid, input close_price, input series_start, output ready);
endinterface

interface macd_out_if;
    logic                               valid;
    logic                               ready;
    logic signed [macd_pkg::DIF_W-1:0]  dif_value;
    logic signed [macd_pkg::DIF_W-1:0]  dea_value;
    logic signed [macd_pkg::HIST_W-1:0] histogram;

    modport source (output valid, output dif_value, output dea_value, output histogram,
                    input ready);
    modport sink   (input valid, input dif_value, input dea_value, input histogram,
                    output ready);
endinterface

interface macd_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [macd_pkg::CFG_IDX_W-1:0]    index;
    logic [macd_pkg::CFG_W-1:0]        data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/macd_mul.sv]
module macd_mul (
    input  logic signed [macd_pkg::DIFF_W-1:0] i_diff,
    input  macd_pkg::t_weight                  i_weight,
    input  logic                               i_hi_sel,
    output logic signed [macd_pkg::PROD_W-1:0] o_product
);

    logic        [macd_pkg::LO_W-1:0] lo;
    logic        [macd_pkg::HI_W-1:0] hi;
    logic signed [macd_pkg::MA_W-1:0] op_a;
    logic signed [macd_pkg::MB_W-1:0] op_b;

    assign lo = i_diff[macd_pkg::LO_W-1:0];
    assign hi = i_diff[macd_pkg::DIFF_W-1:macd_pkg::LO_W];

    // low half is unsigned, high half carries the sign
    assign op_a = i_hi_sel ? {{(macd_pkg::MA_W-macd_pkg::HI_W){hi[macd_pkg::HI_W-1]}}, hi}
                           : {1'b0, lo};
    assign op_b = {1'b0, i_weight};

    assign o_product = op_a * op_b;

endmodule

[rtl/macd_wgt.sv]
module macd_wgt (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    macd_cfg_if.sink             i_cfg,
    output macd_pkg::t_weights   o_weights,
    output logic                 o_busy
);

    logic                              r_busy;
    logic [macd_pkg::CFG_IDX_W-1:0]    r_dst;
    logic [macd_pkg::DEN_W-1:0]        r_den;
    logic [macd_pkg::DVD_W-1:0]        r_dvd;
    logic [macd_pkg::DEN_W-1:0]        r_rem;
    logic [macd_pkg::DVD_W-1:0]        r_quo;
    logic [macd_pkg::DCNT_W-1:0]       r_cnt;
    macd_pkg::t_weights                r_weights;

    logic                              cfg_xfer;
    logic                              cfg_known;
    logic [macd_pkg::DEN_W-1:0]        den;
    logic [macd_pkg::DEN_W:0]          rem_sh;
    logic                              ge;
    logic [macd_pkg::DEN_W-1:0]        n_rem;
    logic [macd_pkg::DVD_W-1:0]        n_quo;
    macd_pkg::t_weight                 n_weight;

    assign cfg_xfer  = i_cfg.valid && i_cfg.ready;
    assign cfg_known = (i_cfg.index == macd_pkg::CFG_IDX_FAST) ||
                       (i_cfg.index == macd_pkg::CFG_IDX_SLOW) ||
                       (i_cfg.index == macd_pkg::CFG_IDX_SIGNAL);

    // period zero behaves as period one
    assign den = (i_cfg.data == '0) ? macd_pkg::DEN_W'(2)
                                    : {1'b0, i_cfg.data} + macd_pkg::DEN_W'(1);

    // one restoring division step per cycle
    assign rem_sh   = {r_rem, r_dvd[macd_pkg::DVD_W-1]};
    assign ge       = rem_sh >= {1'b0, r_den};
    assign n_rem    = ge ? macd_pkg::DEN_W'(rem_sh - {1'b0, r_den})
                         : rem_sh[macd_pkg::DEN_W-1:0];
    assign n_quo    = {r_quo[macd_pkg::DVD_W-2:0], ge};
    assign n_weight = n_quo[macd_pkg::W_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy           <= 1'b0;
            r_weights.fast   <= macd_pkg::FAST_W_RST;
            r_weights.slow   <= macd_pkg::SLOW_W_RST;
            r_weights.signal <= macd_pkg::SIGNAL_W_RST;
        end else if (cfg_xfer) begin
            if (cfg_known) begin
                r_busy <= 1'b1;
                r_dst  <= i_cfg.index;
                r_den  <= den;
                r_dvd  <= macd_pkg::DVD_W'(macd_pkg::W_NUM) +
                          macd_pkg::DVD_W'(den >> 1);
                r_rem  <= '0;
                r_quo  <= '0;
                r_cnt  <= macd_pkg::DCNT_W'(macd_pkg::DVD_W - 1);
            end
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
            r_dvd <= r_dvd << 1;
            r_cnt <= r_cnt - macd_pkg::DCNT_W'(1);
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
                case (r_dst)
                    macd_pkg::CFG_IDX_FAST:   r_weights.fast   <= n_weight;
                    macd_pkg::CFG_IDX_SLOW:   r_weights.slow   <= n_weight;
                    macd_pkg::CFG_IDX_SIGNAL: r_weights.signal <= n_weight;
                    default:                  r_weights        <= r_weights;
                endcase
            end
        end
    end

    assign i_cfg.ready = !r_busy;
    assign o_weights   = r_weights;
    assign o_busy      = r_busy;

endmodule

[rtl/macd_indicator_filter.sv]
// MACD filter: one result (DIF, DEA, histogram) per closing price. A regular item
// is accepted in the idle state, and its result register is loaded in S_FIN once
// the output register is free; only then is the next item taken. A series-start
// item reloads all averages and goes straight to S_FIN to yield its all-zero
// result. The work is done by one shared 30x26-bit multiplier: each of the three
// EMA updates takes an error subtract, two partial products, an accumulate and an
// average update, one per cycle. A finished result waits in the output register
// without blocking the next item until the following result is ready. A period
// write to a known index starts a weight division (one quotient bit per cycle);
// no item and no further write is taken until it completes.
module macd_indicator_filter (
    input  logic       i_clk,
    input  logic       i_rst_n,
    macd_in_if.sink    i_price,
    macd_cfg_if.sink   i_cfg,
    macd_out_if.source o_result
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_PREP = 4'd1;
    localparam logic [3:0] S_MLO  = 4'd2;
    localparam logic [3:0] S_MHI  = 4'd3;
    localparam logic [3:0] S_ACC  = 4'd4;
    localparam logic [3:0] S_UPD  = 4'd5;
    localparam logic [3:0] S_DIF  = 4'd6;
    localparam logic [3:0] S_FIN  = 4'd7;

    localparam int DW = macd_pkg::DIFF_W;
    localparam int FB = macd_pkg::WEIGHT_FRAC_BITS;

    macd_pkg::t_weights                         weights;
    logic                                       wgt_busy;

    logic [3:0]                                 r_state;
    logic [macd_pkg::CFG_IDX_W-1:0]             r_sel;
    logic [macd_pkg::PRICE_WIDTH-1:0]           r_price;
    logic [macd_pkg::AVG_W-1:0]                 r_fast;
    logic [macd_pkg::AVG_W-1:0]                 r_slow;
    logic signed [macd_pkg::SIG_W-1:0]          r_sig;
    logic signed [macd_pkg::SIG_W-1:0]          r_dif;
    logic signed [DW-1:0]                       r_diff;
    logic signed [macd_pkg::ACC_W-1:0]          r_acc;
    logic signed [macd_pkg::PROD_W-1:0]         r_prod;
    logic                                       r_out_valid;
    logic signed [macd_pkg::DIF_W-1:0]          r_o_dif;
    logic signed [macd_pkg::DIF_W-1:0]          r_o_dea;
    logic signed [macd_pkg::HIST_W-1:0]         r_o_hist;

    logic                                       in_xfer;
    logic signed [DW-1:0]                       sig_ext;
    logic signed [DW-1:0]                       dif_ext;
    logic signed [DW-1:0]                       avg_ext;
    logic signed [DW-1:0]                       tgt_ext;
    macd_pkg::t_weight                          w_sel;
    logic signed [macd_pkg::PROD_W-1:0]         product;
    logic signed [macd_pkg::ACC_W-1:0]          acc_sh;
    logic signed [DW-1:0]                       n_avg;
    logic signed [DW-1:0]                       gap;
    logic signed [DW-1:0]                       gap_sh;
    logic signed [macd_pkg::HIST_CMP_W-1:0]     hist_raw;
    logic signed [macd_pkg::HIST_CMP_W-1:0]     hist_sat;
    logic [macd_pkg::AVG_W-1:0]                 x_full;
    logic                                       out_free;

    macd_wgt u_wgt (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (i_cfg),
        .o_weights (weights),
        .o_busy    (wgt_busy)
    );

    macd_mul u_mul (
        .i_diff    (r_diff),
        .i_weight  (w_sel),
        .i_hi_sel  (r_state == S_MHI),
        .o_product (product)
    );

    assign in_xfer  = i_price.valid && i_price.ready;
    assign out_free = !r_out_valid || o_result.ready;
    assign x_full   = {i_price.close_price, {FB{1'b0}}};

    assign sig_ext = {{(DW-macd_pkg::SIG_W){r_sig[macd_pkg::SIG_W-1]}}, r_sig};
    assign dif_ext = {{(DW-macd_pkg::SIG_W){r_dif[macd_pkg::SIG_W-1]}}, r_dif};

    always_comb begin
        case (r_sel)
            macd_pkg::CFG_IDX_FAST: begin
                avg_ext = {{(DW-macd_pkg::AVG_W){1'b0}}, r_fast};
                tgt_ext = {{(DW-macd_pkg::AVG_W){1'b0}}, r_price, {FB{1'b0}}};
                w_sel   = weights.fast;
            end
            macd_pkg::CFG_IDX_SLOW: begin
                avg_ext = {{(DW-macd_pkg::AVG_W){1'b0}}, r_slow};
                tgt_ext = {{(DW-macd_pkg::AVG_W){1'b0}}, r_price, {FB{1'b0}}};
                w_sel   = weights.slow;
            end
            default: begin
                avg_ext = sig_ext;
                tgt_ext = dif_ext;
                w_sel   = weights.signal;
            end
        endcase
    end

    // floor(err * w / 2^FRAC) added to the running average
    assign acc_sh = r_acc >>> FB;
    assign n_avg  = avg_ext + DW'(acc_sh);

    // histogram: floor(2 * gap / 2^FRAC), then clamp
    assign gap      = dif_ext - sig_ext;
    assign gap_sh   = gap >>> (FB - 1);
    assign hist_raw = gap_sh[macd_pkg::HIST_CMP_W-1:0];
    assign hist_sat = (hist_raw > macd_pkg::HIST_MAX) ? macd_pkg::HIST_MAX :
                      (hist_raw < macd_pkg::HIST_MIN) ? macd_pkg::HIST_MIN : hist_raw;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_sel       <= macd_pkg::CFG_IDX_FAST;
            r_out_valid <= 1'b0;
            r_fast      <= '0;
            r_slow      <= '0;
            r_sig       <= '0;
        end else begin
            // a result loaded in S_FIN takes over the slot in the same cycle
            if (r_out_valid && o_result.ready && (r_state != S_FIN)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        r_price <= i_price.close_price;
                        r_sel   <= macd_pkg::CFG_IDX_FAST;
                        if (i_price.series_start) begin
                            r_fast  <= x_full;
                            r_slow  <= x_full;
                            r_sig   <= '0;
                            r_dif   <= '0;
                            r_state <= S_FIN;
                        end else begin
                            r_state <= S_PREP;
                        end
                    end
                end
                S_PREP: begin
                    r_diff  <= tgt_ext - avg_ext;
                    r_state <= S_MLO;
                end
                S_MLO: begin
                    r_acc   <= {{(macd_pkg::ACC_W-macd_pkg::PROD_W){product[macd_pkg::PROD_W-1]}},
                                product};
                    r_state <= S_MHI;
                end
                S_MHI: begin
                    r_prod  <= product;
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    r_acc   <= r_acc + ({{(macd_pkg::ACC_W-macd_pkg::PROD_W){
                                          r_prod[macd_pkg::PROD_W-1]}}, r_prod}
                                        << macd_pkg::LO_W);
                    r_state <= S_UPD;
                end
                S_UPD: begin
                    case (r_sel)
                        macd_pkg::CFG_IDX_FAST: begin
                            r_fast  <= n_avg[macd_pkg::AVG_W-1:0];
                            r_sel   <= macd_pkg::CFG_IDX_SLOW;
                            r_state <= S_PREP;
                        end
                        macd_pkg::CFG_IDX_SLOW: begin
                            r_slow  <= n_avg[macd_pkg::AVG_W-1:0];
                            r_state <= S_DIF;
                        end
                        default: begin
                            r_sig   <= n_avg[macd_pkg::SIG_W-1:0];
                            r_state <= S_FIN;
                        end
                    endcase
                end
                S_DIF: begin
                    r_dif   <= macd_pkg::SIG_W'({1'b0, r_fast} - {1'b0, r_slow});
                    r_sel   <= macd_pkg::CFG_IDX_SIGNAL;
                    r_state <= S_PREP;
                end
                S_FIN: begin
                    // hold until the output register is free
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_o_dif     <= macd_pkg::DIF_W'(r_dif >>> FB);
                        r_o_dea     <= macd_pkg::DIF_W'(r_sig >>> FB);
                        r_o_hist    <= hist_sat[macd_pkg::HIST_W-1:0];
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_price.ready      = (r_state == S_IDLE) && !wgt_busy;
    assign o_result.valid     = r_out_valid;
    assign o_result.dif_value = r_o_dif;
    assign o_result.dea_value = r_o_dea;
    assign o_result.histogram = r_o_hist;

`ifndef SYNTHESIS
    a_weight_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        weights.fast <= macd_pkg::WEIGHT_ONE && weights.slow <= macd_pkg::WEIGHT_ONE &&
        weights.signal <= macd_pkg::WEIGHT_ONE)
        else $error("weight above one");

    a_start_reload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer && i_price.series_start |=> r_fast == r_slow && r_sig == '0 && r_dif == '0)
        else $error("series start did not reload averages");

    a_cfg_blocks_items: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg.valid && i_cfg.ready &&
        (i_cfg.index == macd_pkg::CFG_IDX_FAST || i_cfg.index == macd_pkg::CFG_IDX_SLOW ||
         i_cfg.index == macd_pkg::CFG_IDX_SIGNAL) |=> !i_price.ready)
        else $error("item accepted during weight update");

    a_hist_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_o_hist <= macd_pkg::HIST_MAX && r_o_hist >= macd_pkg::HIST_MIN)
        else $error("histogram outside saturation limits");
`endif

endmodule

[tb/tb_macd_indicator_filter.sv]
module tb_macd_indicator_filter;

    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int unsigned RANDOM_ITEMS = 700;
    localparam int unsigned TAIL_ITEMS   = 40;
    localparam int unsigned DRAIN_CYCLES = 40;

    // index 3 maps to no register
    localparam logic [macd_pkg::CFG_IDX_W-1:0] CFG_IDX_UNUSED = 2'd3;

    localparam logic [macd_pkg::PRICE_WIDTH-1:0] PRICE_MAX  = '1;
    localparam logic [macd_pkg::CFG_W-1:0]       PERIOD_MAX = '1;
    localparam logic signed [95:0]               HIST_LIMIT = 96'sd8589934590;

    typedef struct packed {
        logic signed [macd_pkg::DIF_W-1:0]  dif;
        logic signed [macd_pkg::DIF_W-1:0]  dea;
        logic signed [macd_pkg::HIST_W-1:0] hist;
    } macd_result_t;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic idling_on;
    int unsigned error_count;
    int unsigned cycle_count;

    // mirror of the filter state
    logic signed [95:0] fast_avg;
    logic signed [95:0] slow_avg;
    logic signed [95:0] signal_avg;
    macd_pkg::t_weight fast_weight;
    macd_pkg::t_weight slow_weight;
    macd_pkg::t_weight signal_weight;

    macd_result_t expected_results[$];

    macd_in_if  price_if();
    macd_cfg_if cfg_if();
    macd_out_if result_if();

    macd_indicator_filter u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_price  (price_if),
        .i_cfg    (cfg_if),
        .o_result (result_if)
    );

    always #5 i_clk = ~i_clk;

    function automatic macd_pkg::t_weight weight_for(input logic [macd_pkg::CFG_W-1:0] period);
        longint unsigned den;
        den = 64'(period) + 64'd1;
        if (period == '0) begin
            den = 64'd2;
        end
        return macd_pkg::t_weight'(((64'd2 << macd_pkg::WEIGHT_FRAC_BITS) + den / 2) / den);
    endfunction

    // avg + floor((target - avg) * w)
    function automatic logic signed [95:0] ema_update(input logic signed [95:0] avg,
                                                      input logic signed [95:0] target,
                                                      input macd_pkg::t_weight w);
        logic signed [95:0] prod;
        prod = (target - avg) * $signed({1'b0, w});
        return avg + (prod >>> macd_pkg::WEIGHT_FRAC_BITS);
    endfunction

    function automatic macd_result_t macd_step(
        input logic [macd_pkg::PRICE_WIDTH-1:0] price,
        input logic start);
        logic signed [95:0] target;
        logic signed [95:0] dif_full;
        logic signed [95:0] dif_q;
        logic signed [95:0] dea_q;
        logic signed [95:0] spread;
        macd_result_t r;
        target = $signed({64'd0, price}) <<< macd_pkg::WEIGHT_FRAC_BITS;
        if (start) begin
            fast_avg   = target;
            slow_avg   = target;
            signal_avg = '0;
            dif_full   = '0;
        end else begin
            fast_avg   = ema_update(fast_avg, target, fast_weight);
            slow_avg   = ema_update(slow_avg, target, slow_weight);
            dif_full   = fast_avg - slow_avg;
            signal_avg = ema_update(signal_avg, dif_full, signal_weight);
        end
        dif_q  = dif_full >>> macd_pkg::WEIGHT_FRAC_BITS;
        dea_q  = signal_avg >>> macd_pkg::WEIGHT_FRAC_BITS;
        spread = ((dif_full - signal_avg) <<< 1) >>> macd_pkg::WEIGHT_FRAC_BITS;
        if (spread > HIST_LIMIT) begin
            spread = HIST_LIMIT;
        end else if (spread < -HIST_LIMIT) begin
            spread = -HIST_LIMIT;
        end
        r.dif  = dif_q[macd_pkg::DIF_W-1:0];
        r.dea  = dea_q[macd_pkg::DIF_W-1:0];
        r.hist = spread[macd_pkg::HIST_W-1:0];
        return r;
    endfunction

    task automatic compare_field(input string name,
                                 input logic signed [macd_pkg::HIST_W-1:0] want,
                                 input logic signed [macd_pkg::HIST_W-1:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
            error_count++;
        end
    endtask

    always @(posedge i_clk) begin : result_check
        macd_result_t want;
        if (i_rst_n && result_if.valid && result_if.ready) begin
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result: expected none, got dif %0d dea %0d hist %0d",
                         $time, result_if.dif_value, result_if.dea_value, result_if.histogram);
                error_count++;
            end else begin
                want = expected_results.pop_front();
                compare_field("dif_value", macd_pkg::HIST_W'($signed(want.dif)),
                              macd_pkg::HIST_W'($signed(result_if.dif_value)));
                compare_field("dea_value", macd_pkg::HIST_W'($signed(want.dea)),
                              macd_pkg::HIST_W'($signed(result_if.dea_value)));
                compare_field("histogram", want.hist, result_if.histogram);
            end
        end
    end

    // result back-pressure in bursts
    initial begin : result_stall
        int unsigned stall_left;
        stall_left = 0;
        result_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall_left != 0) begin
                result_if.ready = 1'b0;
                stall_left--;
            end else if (idling_on && $urandom_range(0, 5) == 0) begin
                result_if.ready = 1'b0;
                stall_left = $urandom_range(1, 5) - 1;
            end else begin
                result_if.ready = 1'b1;
            end
        end
    end

    initial begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    task automatic wait_drained();
        while (expected_results.size() != 0) begin
            @(posedge i_clk);
        end
        @(negedge i_clk);
    endtask

    task automatic send_price(input logic [macd_pkg::PRICE_WIDTH-1:0] price,
                              input logic start);
        int unsigned bursts;
        bursts = 0;
        // up to four idle bursts back to back so a gap can outlast the busy window
        if (idling_on && $urandom_range(0, 2) == 0) begin
            bursts = $urandom_range(1, 4);
        end
        repeat (bursts) begin
            repeat ($urandom_range(1, 5)) @(negedge i_clk);
        end
        price_if.close_price  = price;
        price_if.series_start = start;
        price_if.valid        = 1'b1;
        do @(posedge i_clk); while (!price_if.ready);
        expected_results.push_back(macd_step(price, start));
        @(negedge i_clk);
        price_if.valid = 1'b0;
    endtask

    task automatic write_period(input logic [macd_pkg::CFG_IDX_W-1:0] idx,
                                input logic [macd_pkg::CFG_W-1:0] period);
        wait_drained();
        cfg_if.index = idx;
        cfg_if.data  = period;
        cfg_if.valid = 1'b1;
        do @(posedge i_clk); while (!cfg_if.ready);
        case (idx)
            macd_pkg::CFG_IDX_FAST:   fast_weight   = weight_for(period);
            macd_pkg::CFG_IDX_SLOW:   slow_weight   = weight_for(period);
            macd_pkg::CFG_IDX_SIGNAL: signal_weight = weight_for(period);
            default: ;
        endcase
        @(negedge i_clk);
        cfg_if.valid = 1'b0;
    endtask

    function automatic logic [macd_pkg::CFG_W-1:0] pick_period();
        case ($urandom_range(0, 7))
            0:       return 10'd1;
            1:       return PERIOD_MAX;
            2:       return macd_pkg::CFG_W'($urandom_range(1, 1023));
            default: return macd_pkg::CFG_W'($urandom_range(2, 40));
        endcase
    endfunction

    function automatic logic [macd_pkg::PRICE_WIDTH-1:0] next_price(
        input logic [macd_pkg::PRICE_WIDTH-1:0] prev,
        input int unsigned style);
        longint signed walked;
        case (style)
            0: return $urandom();
            1, 3: begin
                walked = (style == 1) ? $urandom_range(0, 1 << 20) : $urandom_range(0, 1 << 28);
                if ($urandom_range(0, 1) == 0) begin
                    walked = -walked;
                end
                walked = walked + longint'(prev);
                if (walked < 0) begin
                    walked = 0;
                end else if (walked > longint'(PRICE_MAX)) begin
                    walked = longint'(PRICE_MAX);
                end
                return walked[macd_pkg::PRICE_WIDTH-1:0];
            end
            default: begin
                case ($urandom_range(0, 2))
                    0:       return '0;
                    1:       return PRICE_MAX;
                    default: return $urandom();
                endcase
            end
        endcase
    endfunction

    // averages smooth up from zero when no series has started
    task automatic test_before_first_start();
        send_price(PRICE_MAX, 1'b0);
        send_price(32'h0001_0000, 1'b0);
        send_price('0, 1'b0);
    endtask

    task automatic test_extreme_prices();
        send_price(PRICE_MAX, 1'b1);
        send_price('0, 1'b0);
        send_price(PRICE_MAX, 1'b0);
        send_price('0, 1'b1);
        send_price(PRICE_MAX, 1'b0);
    endtask

    task automatic test_unused_index();
        write_period(CFG_IDX_UNUSED, 10'd1);
        send_price(32'h1234_5678, 1'b0);
        send_price(32'h8765_4321, 1'b0);
    endtask

    // swing DIF against a lagging DEA until the histogram clamps both ways
    task automatic test_histogram_clamp();
        write_period(macd_pkg::CFG_IDX_FAST, 10'd1);
        write_period(macd_pkg::CFG_IDX_SLOW, PERIOD_MAX);
        write_period(macd_pkg::CFG_IDX_SIGNAL, 10'd1);
        send_price('0, 1'b1);
        send_price(PRICE_MAX, 1'b0);
        write_period(macd_pkg::CFG_IDX_FAST, PERIOD_MAX);
        write_period(macd_pkg::CFG_IDX_SLOW, 10'd1);
        write_period(macd_pkg::CFG_IDX_SIGNAL, PERIOD_MAX);
        send_price(PRICE_MAX, 1'b0);
        write_period(macd_pkg::CFG_IDX_FAST, 10'd1);
        write_period(macd_pkg::CFG_IDX_SLOW, PERIOD_MAX);
        send_price('0, 1'b0);
        write_period(macd_pkg::CFG_IDX_SIGNAL, 10'd1);
        send_price('0, 1'b0);
        write_period(macd_pkg::CFG_IDX_FAST, PERIOD_MAX);
        write_period(macd_pkg::CFG_IDX_SLOW, 10'd1);
        write_period(macd_pkg::CFG_IDX_SIGNAL, PERIOD_MAX);
        send_price('0, 1'b0);
        write_period(macd_pkg::CFG_IDX_FAST, 10'd1);
        write_period(macd_pkg::CFG_IDX_SLOW, PERIOD_MAX);
        send_price(PRICE_MAX, 1'b0);
    endtask

    task automatic test_random_series();
        int unsigned sent;
        int unsigned series_len;
        int unsigned style;
        logic [macd_pkg::PRICE_WIDTH-1:0] price;
        logic start;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            if ($urandom_range(0, 2) == 0) begin
                if ($urandom_range(0, 1) == 0) begin
                    write_period(macd_pkg::CFG_IDX_FAST, pick_period());
                end
                if ($urandom_range(0, 1) == 0) begin
                    write_period(macd_pkg::CFG_IDX_SLOW, pick_period());
                end
                if ($urandom_range(0, 1) == 0) begin
                    write_period(macd_pkg::CFG_IDX_SIGNAL, pick_period());
                end
            end
            idling_on  = ($urandom_range(0, 3) != 0);
            series_len = $urandom_range(4, 50);
            style      = $urandom_range(0, 3);
            price      = $urandom();
            for (int i = 0; i < series_len; i++) begin
                // mostly clean series; a few run on or restart midway
                if (i == 0) begin
                    start = ($urandom_range(0, 9) != 0);
                end else begin
                    start = ($urandom_range(0, 49) == 0);
                end
                send_price(price, start);
                price = next_price(price, style);
            end
            sent += series_len;
        end
    endtask

    task automatic test_steady_tail();
        logic [macd_pkg::PRICE_WIDTH-1:0] price;
        idling_on = 1'b0;
        write_period(macd_pkg::CFG_IDX_FAST, macd_pkg::FAST_PERIOD_RST);
        write_period(macd_pkg::CFG_IDX_SLOW, macd_pkg::SLOW_PERIOD_RST);
        write_period(macd_pkg::CFG_IDX_SIGNAL, macd_pkg::SIGNAL_PERIOD_RST);
        price = $urandom();
        for (int i = 0; i < TAIL_ITEMS; i++) begin
            send_price(price, i == 0);
            price = next_price(price, 1);
        end
    endtask

    initial begin
        i_rst_n               = 1'b0;
        idling_on             = 1'b1;
        error_count           = 0;
        price_if.valid        = 1'b0;
        price_if.close_price  = '0;
        price_if.series_start = 1'b0;
        cfg_if.valid          = 1'b0;
        cfg_if.index          = '0;
        cfg_if.data           = '0;
        fast_avg              = '0;
        slow_avg              = '0;
        signal_avg            = '0;
        fast_weight           = weight_for(macd_pkg::FAST_PERIOD_RST);
        slow_weight           = weight_for(macd_pkg::SLOW_PERIOD_RST);
        signal_weight         = weight_for(macd_pkg::SIGNAL_PERIOD_RST);
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_before_first_start();
        test_extreme_prices();
        test_unused_index();
        test_histogram_clamp();
        test_random_series();
        test_steady_tail();

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule
